/* rtl/core/touch_gesture_classifier_core_defines.svh */
// Assertion macros for the touch gesture classifier core.
// Used by rtl/core/touch_gesture_classifier_core.sv; depends on nothing else.
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tgc_pkg.sv */
// Package for the touch gesture classifier core: widths, codes and the zone lookup.
// No dependencies; imported by touch_gesture_classifier_core.
`default_nettype none

package tgc_pkg;

    localparam int COORD_BITS      = 12;
    localparam int TIMER_BITS      = 16;
    localparam int BTN_BITS        = 3;
    localparam int ROW_BITS        = 3;
    localparam int IDX_BITS        = 4;
    localparam int ZONES           = 9;
    localparam int TAP_MASK_BITS   = 45;
    localparam int TAP_BIT_BITS    = $clog2(TAP_MASK_BITS);
    localparam int SWIPE_MASK_BITS = 8;
    localparam int SWIPE_BIT_BITS  = $clog2(SWIPE_MASK_BITS);
    localparam int CFG_DATA_BITS   = 45;
    localparam int CFG_ADDR_BITS   = 3;

    // slave tdata layout: pos_x, pos_y, buttons, focus_in_reader, gesture_enable
    localparam int S_X_LSB       = 0;
    localparam int S_Y_LSB       = S_X_LSB + COORD_BITS;
    localparam int S_BTN_LSB     = S_Y_LSB + COORD_BITS;
    localparam int S_FOCUS_BIT   = S_BTN_LSB + BTN_BITS;
    localparam int S_GE_BIT      = S_FOCUS_BIT + 1;
    localparam int S_USED_BITS   = S_GE_BIT + 1;
    localparam int S_TDATA_BITS  = ((S_USED_BITS + 7) / 8) * 8;

    // master tdata layout: action_row, action_index, emit_key, filtered
    localparam int M_USED_BITS   = ROW_BITS + IDX_BITS + 2;
    localparam int M_TDATA_BITS  = ((M_USED_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TAP   = 2'd1,
        KIND_SWIPE = 2'd2,
        KIND_LONG  = 2'd3
    } t_kind;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_LEFT_END     = 3'd0,
        CFG_RIGHT_START  = 3'd1,
        CFG_TOP_END      = 3'd2,
        CFG_BOTTOM_START = 3'd3,
        CFG_MIN_SWIPE    = 3'd4,
        CFG_LONG_TICKS   = 3'd5,
        CFG_TAP_MASK     = 3'd6,
        CFG_SWIPE_MASK   = 3'd7
    } t_cfg_idx;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [BTN_BITS-1:0] BTN_RELEASED = 3'd0;
    localparam logic [BTN_BITS-1:0] BTN_ONE      = 3'd1;
    localparam logic [BTN_BITS-1:0] BTN_TWO      = 3'd2;

    localparam logic [ROW_BITS-1:0] ROW_SINGLE      = 3'd0;
    localparam logic [ROW_BITS-1:0] ROW_TWO         = 3'd1;
    localparam logic [ROW_BITS-1:0] ROW_TWO_READER  = 3'd2;
    localparam logic [ROW_BITS-1:0] ROW_LONG        = 3'd3;
    localparam logic [ROW_BITS-1:0] ROW_LONG_READER = 3'd4;
    localparam logic [ROW_BITS-1:0] ROW_SWIPE_OUT   = 3'd0;
    localparam logic [ROW_BITS-1:0] ROW_SWIPE_IN    = 3'd1;

    localparam logic [IDX_BITS-1:0] DIR_UP    = 4'd0;
    localparam logic [IDX_BITS-1:0] DIR_RIGHT = 4'd1;
    localparam logic [IDX_BITS-1:0] DIR_DOWN  = 4'd2;
    localparam logic [IDX_BITS-1:0] DIR_LEFT  = 4'd3;

    localparam logic [COORD_BITS-1:0]    RST_LEFT_END     = COORD_BITS'(180);
    localparam logic [COORD_BITS-1:0]    RST_RIGHT_START  = COORD_BITS'(420);
    localparam logic [COORD_BITS-1:0]    RST_TOP_END      = COORD_BITS'(240);
    localparam logic [COORD_BITS-1:0]    RST_BOTTOM_START = COORD_BITS'(560);
    localparam logic [COORD_BITS-1:0]    RST_MIN_SWIPE    = COORD_BITS'(50);
    localparam logic [TIMER_BITS-1:0]    RST_LONG_TICKS   = TIMER_BITS'(500);
    localparam logic [TAP_MASK_BITS-1:0] RST_TAP_MASK     = 45'd10445360463871;
    localparam logic [SWIPE_MASK_BITS-1:0] RST_SWIPE_MASK = 8'hFF;

    typedef struct packed {
        t_kind                kind;
        logic [ROW_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  index;
        logic                 emit_key;
        logic                 filtered;
    } t_result;

    function automatic logic [IDX_BITS-1:0] zone_of(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] left_end,
        input logic [COORD_BITS-1:0] right_start,
        input logic [COORD_BITS-1:0] top_end,
        input logic [COORD_BITS-1:0] bottom_start
    );
        logic [1:0] zr;
        logic [1:0] zc;
        if (y < top_end) begin
            zr = 2'd0;
        end else if (y < bottom_start) begin
            zr = 2'd1;
        end else begin
            zr = 2'd2;
        end
        if (x < left_end) begin
            zc = 2'd0;
        end else if (x >= right_start) begin
            zc = 2'd2;
        end else begin
            zc = 2'd1;
        end
        return IDX_BITS'(zr) * IDX_BITS'(3) + IDX_BITS'(zc);
    endfunction

    function automatic logic [TAP_BIT_BITS-1:0] tap_bit(
        input logic [ROW_BITS-1:0] row,
        input logic [IDX_BITS-1:0] zone
    );
        return TAP_BIT_BITS'(row) * TAP_BIT_BITS'(ZONES) + TAP_BIT_BITS'(zone);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/touch_gesture_classifier_core.sv */
// Touch gesture classifier core: tap zone, swipe and long-tap classification.
// Depends on tgc_pkg and touch_gesture_classifier_core_defines.svh.
//
//  channel   direction  transaction
//  s_axis    in         one touch report or one timer tick (tuser = op)
//  m_axis    out        one action (tuser = action_kind)
//  cfg       in         one register write, index i_cfg_addr
//
// One item per cycle sustained while m_axis does not stall; m_axis is driven from the result register.
// Input register, single classification stage, result register.
// A tick that yields no action leaves the result data untouched and sends nothing on m_axis.
// m_axis stall holds the result and backs up into s_axis tready.
// Reset is synchronous: valid flags, gesture state and config registers return to defaults; data registers do not.
`default_nettype none

`include "touch_gesture_classifier_core_defines.svh"

module touch_gesture_classifier_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // pos_x, pos_y, buttons, focus_in_reader, gesture_enable (lowest bit up)
    input  wire logic [tgc_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
    // op
    input  wire logic                               s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // action_row, action_index, emit_key, filtered (lowest bit up)
    output logic [tgc_pkg::M_TDATA_BITS-1:0]        m_axis_tdata,
    // action_kind
    output logic [1:0]                              m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               i_cfg_we,
    input  wire logic [tgc_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  wire logic [tgc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tgc_pkg::*;

    logic [COORD_BITS-1:0]      r_left_end, r_right_start, r_top_end, r_bottom_start;
    logic [COORD_BITS-1:0]      r_min_swipe;
    logic [TIMER_BITS-1:0]      r_long_ticks;
    logic [TAP_MASK_BITS-1:0]   r_tap_mask;
    logic [SWIPE_MASK_BITS-1:0] r_swipe_mask;

    logic                       r_in_valid;
    logic                       r_in_op;
    logic [COORD_BITS-1:0]      r_in_x, r_in_y;
    logic [BTN_BITS-1:0]        r_in_btn;
    logic                       r_in_focus, r_in_ge;

    logic [BTN_BITS-1:0]        r_prev_btn, n_prev_btn;
    logic [COORD_BITS-1:0]      r_press_x, n_press_x, r_press_y, n_press_y;
    logic                       r_press_reader, n_press_reader;
    logic                       r_press_ge, n_press_ge;
    logic                       r_long_done, n_long_done;
    logic                       r_hold_run, n_hold_run;
    logic [TIMER_BITS-1:0]      r_hold_cnt, n_hold_cnt;

    logic                       r_out_valid;
    t_result                    r_out;
    t_result                    res;
    logic                       res_valid;

    logic                       advance;
    logic [COORD_BITS-1:0]      dx, dy;
    logic [IDX_BITS-1:0]        press_zone, cur_zone;
    logic                       moved, single, gest, handled;
    logic [ROW_BITS-1:0]        long_row;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {(M_TDATA_BITS - M_USED_BITS)'(0), r_out.filtered, r_out.emit_key,
                            r_out.index, r_out.row};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_end     <= RST_LEFT_END;
            r_right_start  <= RST_RIGHT_START;
            r_top_end      <= RST_TOP_END;
            r_bottom_start <= RST_BOTTOM_START;
            r_min_swipe    <= RST_MIN_SWIPE;
            r_long_ticks   <= RST_LONG_TICKS;
            r_tap_mask     <= RST_TAP_MASK;
            r_swipe_mask   <= RST_SWIPE_MASK;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_LEFT_END:     r_left_end     <= i_cfg_data[COORD_BITS-1:0];
                CFG_RIGHT_START:  r_right_start  <= i_cfg_data[COORD_BITS-1:0];
                CFG_TOP_END:      r_top_end      <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOTTOM_START: r_bottom_start <= i_cfg_data[COORD_BITS-1:0];
                CFG_MIN_SWIPE:    r_min_swipe    <= i_cfg_data[COORD_BITS-1:0];
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data[TIMER_BITS-1:0];
                CFG_TAP_MASK:     r_tap_mask     <= i_cfg_data[TAP_MASK_BITS-1:0];
                CFG_SWIPE_MASK:   r_swipe_mask   <= i_cfg_data[SWIPE_MASK_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_x     <= s_axis_tdata[S_X_LSB +: COORD_BITS];
            r_in_y     <= s_axis_tdata[S_Y_LSB +: COORD_BITS];
            r_in_btn   <= s_axis_tdata[S_BTN_LSB +: BTN_BITS];
            r_in_focus <= s_axis_tdata[S_FOCUS_BIT];
            r_in_ge    <= s_axis_tdata[S_GE_BIT];
        end
    end

    assign dx = (r_in_x > r_press_x) ? (r_in_x - r_press_x) : (r_press_x - r_in_x);
    assign dy = (r_in_y > r_press_y) ? (r_in_y - r_press_y) : (r_press_y - r_in_y);
    assign press_zone = zone_of(r_press_x, r_press_y, r_left_end, r_right_start,
                                r_top_end, r_bottom_start);
    assign cur_zone   = zone_of(r_in_x, r_in_y, r_left_end, r_right_start,
                                r_top_end, r_bottom_start);
    assign moved    = (dx > r_min_swipe) || (dy > r_min_swipe);
    assign single   = (r_prev_btn == BTN_ONE);
    assign gest     = r_press_ge && moved && single;
    assign long_row = r_press_reader ? ROW_LONG_READER : ROW_LONG;

    // classification
    always_comb begin
        n_prev_btn     = r_prev_btn;
        n_press_x      = r_press_x;
        n_press_y      = r_press_y;
        n_press_reader = r_press_reader;
        n_press_ge     = r_press_ge;
        n_long_done    = r_long_done;
        n_hold_run     = r_hold_run;
        n_hold_cnt     = r_hold_cnt;
        res            = '0;
        res_valid      = 1'b0;
        handled        = 1'b0;

        if (r_in_op == OP_TICK) begin
            if (r_hold_run) begin
                if (r_hold_cnt > TIMER_BITS'(1)) begin
                    n_hold_cnt = r_hold_cnt - TIMER_BITS'(1);
                end else begin
                    n_hold_cnt   = '0;
                    n_hold_run   = 1'b0;
                    n_long_done  = 1'b1;
                    res_valid    = 1'b1;
                    res.kind     = KIND_LONG;
                    res.row      = long_row;
                    res.index    = press_zone;
                    res.emit_key = r_tap_mask[tap_bit(long_row, press_zone)];
                end
            end
        end else begin
            res_valid = 1'b1;
            if (r_in_btn != BTN_RELEASED) begin
                if (r_prev_btn == BTN_RELEASED) begin
                    n_press_reader = r_in_focus;
                    n_press_x      = r_in_x;
                    n_press_y      = r_in_y;
                    n_press_ge     = r_in_ge;
                    if (r_in_btn == BTN_ONE) begin
                        n_hold_run = 1'b1;
                        n_hold_cnt = r_long_ticks;
                    end
                end else begin
                    n_hold_run = 1'b0;
                end
            end

            res.filtered = n_press_ge && (r_in_btn != BTN_RELEASED) && (r_prev_btn == r_in_btn);

            if (r_in_btn == BTN_RELEASED && r_prev_btn != BTN_RELEASED) begin
                handled    = single && !gest && !r_press_reader;
                n_hold_run = 1'b0;
                if (r_long_done) begin
                    handled     = 1'b1;
                    n_long_done = 1'b0;
                end
                if (!handled) begin
                    if (gest) begin
                        res.kind = KIND_SWIPE;
                        res.row  = r_press_reader ? ROW_SWIPE_IN : ROW_SWIPE_OUT;
                        if (dx > dy) begin
                            res.index = (r_press_x > r_in_x) ? DIR_LEFT : DIR_RIGHT;
                        end else begin
                            res.index = (r_in_y > r_press_y) ? DIR_DOWN : DIR_UP;
                        end
                        res.emit_key = r_swipe_mask[{res.row[0], res.index[1:0]}];
                    end else begin
                        res.kind = KIND_TAP;
                        if (r_prev_btn == BTN_TWO) begin
                            res.row = r_press_reader ? ROW_TWO_READER : ROW_TWO;
                        end else begin
                            res.row = ROW_SINGLE;
                        end
                        res.index    = cur_zone;
                        res.emit_key = r_tap_mask[tap_bit(res.row, cur_zone)];
                    end
                    if (res.emit_key) begin
                        res.filtered = 1'b1;
                    end
                end
            end
            n_prev_btn = r_in_btn;
        end
    end

    // gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn     <= BTN_RELEASED;
            r_press_x      <= '0;
            r_press_y      <= '0;
            r_press_reader <= 1'b1;
            r_press_ge     <= 1'b1;
            r_long_done    <= 1'b0;
            r_hold_run     <= 1'b0;
            r_hold_cnt     <= '0;
        end else if (advance) begin
            r_prev_btn     <= n_prev_btn;
            r_press_x      <= n_press_x;
            r_press_y      <= n_press_y;
            r_press_reader <= n_press_reader;
            r_press_ge     <= n_press_ge;
            r_long_done    <= n_long_done;
            r_hold_run     <= n_hold_run;
            r_hold_cnt     <= n_hold_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    `TGC_ASSERT_NEXT(a_release_stops_hold, i_clk, i_rst_n,
        advance && r_in_op == OP_REPORT && r_in_btn == BTN_RELEASED, !r_hold_run,
        "hold countdown still running after a release")

    `TGC_ASSERT_NOW(a_long_done_idle, i_clk, i_rst_n,
        r_long_done, !r_hold_run,
        "hold countdown running after a long tap fired")

    `TGC_ASSERT_NOW(a_none_is_empty, i_clk, i_rst_n,
        r_out_valid && r_out.kind == KIND_NONE,
        r_out.row == '0 && r_out.index == '0 && !r_out.emit_key,
        "empty action carries a slot")

endmodule

`default_nettype wire

/* tb/gesture_action_checker.sv */
`timescale 1ns / 1ps
// Action checker for touch_gesture_classifier_core: tracks the press, hold timer and
// thresholds from the observed transactions and compares every output action.
// Depends on tgc_pkg; instantiated by testbench beside the core.
module gesture_action_checker
    import tgc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [S_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                     s_axis_tuser,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [M_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic [1:0]               m_axis_tuser,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_mismatches,
    output int                       o_outstanding
);

    logic [COORD_BITS-1:0]      left_end, right_start, top_end, bottom_start, min_swipe;
    logic [TIMER_BITS-1:0]      hold_ticks;
    logic [TAP_MASK_BITS-1:0]   tap_mask;
    logic [SWIPE_MASK_BITS-1:0] swipe_mask;

    logic [BTN_BITS-1:0]   prev_btn;
    logic [COORD_BITS-1:0] press_x, press_y;
    logic                  press_reader, press_ge, long_done, timer_run;
    logic [TIMER_BITS-1:0] timer_cnt;

    t_result pending_actions[$];

    function automatic logic [IDX_BITS-1:0] grid_zone(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y
    );
        int r;
        int c;
        r = (y < top_end) ? 0 : (y < bottom_start) ? 1 : 2;
        c = (x < left_end) ? 0 : (x >= right_start) ? 2 : 1;
        return IDX_BITS'(r * 3 + c);
    endfunction

    function automatic logic tap_slot_defined(
        input logic [ROW_BITS-1:0] row,
        input logic [IDX_BITS-1:0] zone
    );
        int b;
        b = int'(row) * ZONES + int'(zone);
        return b < TAP_MASK_BITS && tap_mask[b];
    endfunction

    task automatic classify_touch(
        input logic                  op,
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [BTN_BITS-1:0]   nb,
        input logic                  focus,
        input logic                  genable
    );
        t_result               act;
        logic [COORD_BITS-1:0] dx, dy;
        logic                  single, moved, gest, handled;
        act.kind     = KIND_NONE;
        act.row      = '0;
        act.index    = '0;
        act.emit_key = 1'b0;
        act.filtered = 1'b0;
        if (op == OP_TICK) begin
            if (!timer_run) return;
            if (timer_cnt > 1) begin
                timer_cnt = timer_cnt - 1'b1;
                return;
            end
            timer_cnt    = '0;
            timer_run    = 1'b0;
            long_done    = 1'b1;
            act.kind     = KIND_LONG;
            act.row      = press_reader ? ROW_LONG_READER : ROW_LONG;
            act.index    = grid_zone(press_x, press_y);
            act.emit_key = tap_slot_defined(act.row, act.index);
            pending_actions.push_back(act);
            return;
        end
        if (nb != BTN_RELEASED) begin
            if (prev_btn == BTN_RELEASED) begin
                press_reader = focus;
                press_x      = x;
                press_y      = y;
                press_ge     = genable;
                if (nb == BTN_ONE) begin
                    timer_run = 1'b1;
                    timer_cnt = hold_ticks;
                end
            end else begin
                timer_run = 1'b0;
            end
        end
        act.filtered = press_ge && nb != BTN_RELEASED && prev_btn == nb;
        if (nb == BTN_RELEASED && prev_btn != BTN_RELEASED) begin
            single  = prev_btn == BTN_ONE;
            dx      = (x > press_x) ? x - press_x : press_x - x;
            dy      = (y > press_y) ? y - press_y : press_y - y;
            moved   = dx > min_swipe || dy > min_swipe;
            gest    = press_ge && moved && single;
            handled = single && !gest && !press_reader;
            timer_run = 1'b0;
            if (long_done) begin
                handled   = 1'b1;
                long_done = 1'b0;
            end
            if (!handled) begin
                if (gest) begin
                    act.kind = KIND_SWIPE;
                    act.row  = press_reader ? ROW_SWIPE_IN : ROW_SWIPE_OUT;
                    if (dx > dy) begin
                        act.index = (press_x > x) ? DIR_LEFT : DIR_RIGHT;
                    end else begin
                        act.index = (y > press_y) ? DIR_DOWN : DIR_UP;
                    end
                    act.emit_key = swipe_mask[int'(act.row) * 4 + int'(act.index)];
                end else begin
                    act.kind = KIND_TAP;
                    act.row  = ROW_SINGLE;
                    if (prev_btn == BTN_TWO) act.row = press_reader ? ROW_TWO_READER : ROW_TWO;
                    act.index    = grid_zone(x, y);
                    act.emit_key = tap_slot_defined(act.row, act.index);
                end
                if (act.emit_key) act.filtered = 1'b1;
            end
        end
        prev_btn = nb;
        pending_actions.push_back(act);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            left_end     = RST_LEFT_END;
            right_start  = RST_RIGHT_START;
            top_end      = RST_TOP_END;
            bottom_start = RST_BOTTOM_START;
            min_swipe    = RST_MIN_SWIPE;
            hold_ticks   = RST_LONG_TICKS;
            tap_mask     = RST_TAP_MASK;
            swipe_mask   = RST_SWIPE_MASK;
            prev_btn     = BTN_RELEASED;
            press_x      = '0;
            press_y      = '0;
            press_reader = 1'b1;
            press_ge     = 1'b1;
            long_done    = 1'b0;
            timer_run    = 1'b0;
            timer_cnt    = '0;
            o_mismatches = 0;
            pending_actions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LEFT_END:     left_end     = i_cfg_data[COORD_BITS-1:0];
                    CFG_RIGHT_START:  right_start  = i_cfg_data[COORD_BITS-1:0];
                    CFG_TOP_END:      top_end      = i_cfg_data[COORD_BITS-1:0];
                    CFG_BOTTOM_START: bottom_start = i_cfg_data[COORD_BITS-1:0];
                    CFG_MIN_SWIPE:    min_swipe    = i_cfg_data[COORD_BITS-1:0];
                    CFG_LONG_TICKS:   hold_ticks   = i_cfg_data[TIMER_BITS-1:0];
                    CFG_TAP_MASK:     tap_mask     = i_cfg_data[TAP_MASK_BITS-1:0];
                    CFG_SWIPE_MASK:   swipe_mask   = i_cfg_data[SWIPE_MASK_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                classify_touch(s_axis_tuser,
                               s_axis_tdata[S_X_LSB +: COORD_BITS],
                               s_axis_tdata[S_Y_LSB +: COORD_BITS],
                               s_axis_tdata[S_BTN_LSB +: BTN_BITS],
                               s_axis_tdata[S_FOCUS_BIT],
                               s_axis_tdata[S_GE_BIT]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind     = t_kind'(m_axis_tuser);
                got.row      = m_axis_tdata[ROW_BITS-1:0];
                got.index    = m_axis_tdata[ROW_BITS +: IDX_BITS];
                got.emit_key = m_axis_tdata[ROW_BITS + IDX_BITS];
                got.filtered = m_axis_tdata[ROW_BITS + IDX_BITS + 1];
                if (pending_actions.size() == 0) begin
                    $display("%0t: unexpected action, expected none, actual kind %0d row %0d",
                             $time, got.kind, got.row);
                    o_mismatches++;
                end else begin
                    want = pending_actions.pop_front();
                    compare_field("action_kind", int'(want.kind), int'(got.kind));
                    compare_field("action_row", int'(want.row), int'(got.row));
                    compare_field("action_index", int'(want.index), int'(got.index));
                    compare_field("emit_key", int'(want.emit_key), int'(got.emit_key));
                    compare_field("filtered", int'(want.filtered), int'(got.filtered));
                end
            end
        end
        o_outstanding <= pending_actions.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the touch_gesture_classifier_core testbench: clock, reset, threshold
// programming, directed and random touch/tick stimulus, and the final verdict.
// Depends on tgc_pkg, touch_gesture_classifier_core and gesture_action_checker.
module testbench;
    import tgc_pkg::*;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic [S_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     s_axis_tuser  = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;
    logic [1:0]               m_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int swipe_dist     = 50;
    int hold_len       = 500;

    touch_gesture_classifier_core dut (.*);

    gesture_action_checker checker_i (
        .*,
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("[touch_gesture_classifier_core] ERROR");
        $finish;
    end

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        return (v < 0) ? '0 : (v > 4095) ? '1 : COORD_BITS'(v);
    endfunction

    function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] base);
        int mag;
        mag = $urandom_range(1) ? int'($urandom_range(swipe_dist))
                                : swipe_dist + 1 + int'($urandom_range(300));
        return clamp_coord($urandom_range(1) ? int'(base) + mag : int'(base) - mag);
    endfunction

    task automatic send_item(
        input logic                  op,
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [BTN_BITS-1:0]   b,
        input logic                  f,
        input logic                  g
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_BITS'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= S_TDATA_BITS'({g, f, b, y, x});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_report(
        input int x, input int y, input logic [BTN_BITS-1:0] b, input logic f, input logic g
    );
        send_item(OP_REPORT, COORD_BITS'(x), COORD_BITS'(y), b, f, g);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  BTN_BITS'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // hold until every expected action is out and the pipeline is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_thresholds(
        input int le, input int rs, input int te, input int bs, input int msd,
        input int ticks, input logic [TAP_MASK_BITS-1:0] tmask,
        input logic [SWIPE_MASK_BITS-1:0] smask
    );
        settle();
        write_reg(CFG_LEFT_END, CFG_DATA_BITS'(le));
        write_reg(CFG_RIGHT_START, CFG_DATA_BITS'(rs));
        write_reg(CFG_TOP_END, CFG_DATA_BITS'(te));
        write_reg(CFG_BOTTOM_START, CFG_DATA_BITS'(bs));
        write_reg(CFG_MIN_SWIPE, CFG_DATA_BITS'(msd));
        write_reg(CFG_LONG_TICKS, CFG_DATA_BITS'(ticks));
        write_reg(CFG_TAP_MASK, CFG_DATA_BITS'(tmask));
        write_reg(CFG_SWIPE_MASK, CFG_DATA_BITS'(smask));
        i_cfg_we   <= 1'b0;
        swipe_dist = msd;
        hold_len   = ticks;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // press, optional holds and ticks, then release near or far from the press
    task automatic run_gesture();
        logic [BTN_BITS-1:0]   btn;
        logic [COORD_BITS-1:0] px, py;
        logic                  foc, ge;
        int                    roll;
        roll = $urandom_range(99);
        btn  = (roll < 60) ? BTN_ONE : (roll < 80) ? BTN_TWO : BTN_BITS'($urandom_range(7, 3));
        px   = COORD_BITS'($urandom);
        py   = COORD_BITS'($urandom);
        foc  = 1'($urandom);
        ge   = 1'($urandom);
        send_item(OP_REPORT, px, py, btn, foc, ge);
        repeat ($urandom_range(3)) begin
            if ($urandom_range(99) < 75) begin
                send_item(OP_REPORT, clamp_coord(int'(px) + int'($urandom_range(40)) - 20),
                          clamp_coord(int'(py) + int'($urandom_range(40)) - 20),
                          btn, 1'($urandom), 1'($urandom));
            end else begin
                send_item(OP_REPORT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          BTN_BITS'($urandom_range(7, 1)), 1'($urandom), 1'($urandom));
            end
        end
        if (hold_len <= 8) begin
            repeat ($urandom_range(hold_len + 2)) send_tick();
        end else begin
            repeat ($urandom_range(3)) send_tick();
        end
        if ($urandom_range(99) < 10) begin
            send_item(OP_REPORT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      BTN_RELEASED, 1'($urandom), 1'($urandom));
        end else begin
            send_item(OP_REPORT, nudge(px), nudge(py), BTN_RELEASED, 1'($urandom),
                      1'($urandom));
        end
    endtask

    task automatic random_phase(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(99) < 15) begin
                send_item(1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                          BTN_BITS'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                run_gesture();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: idle tick, swipes in every direction, multi-finger, two-finger
        send_tick();
        send_report(0, 0, BTN_ONE, 1'b1, 1'b1);
        send_report(0, 0, BTN_ONE, 1'b1, 1'b1);
        send_report(4095, 4095, BTN_ONE, 1'b1, 1'b1);
        send_report(4095, 4095, BTN_RELEASED, 1'b0, 1'b0);
        send_report(300, 400, BTN_TWO, 1'b1, 1'b0);
        send_report(300, 400, BTN_RELEASED, 1'b1, 1'b0);
        send_report(4095, 0, 3'd7, 1'b0, 1'b1);
        send_report(4095, 0, 3'd3, 1'b0, 1'b1);
        send_report(4095, 0, BTN_RELEASED, 1'b0, 1'b1);
        send_report(100, 100, BTN_ONE, 1'b0, 1'b1);
        send_report(100, 100, BTN_RELEASED, 1'b0, 1'b1);
        send_report(2000, 2000, BTN_ONE, 1'b0, 1'b1);
        send_report(2010, 1000, BTN_RELEASED, 1'b0, 1'b1);
        send_report(2000, 2000, BTN_ONE, 1'b1, 1'b1);
        send_report(1000, 2010, BTN_RELEASED, 1'b1, 1'b1);
        send_report(1000, 1000, BTN_ONE, 1'b0, 1'b1);
        send_report(1100, 1010, BTN_RELEASED, 1'b0, 1'b1);

        // overlapping zones, zero hold length, no slot defined, swipe never reached
        program_thresholds(4095, 0, 4095, 0, 4095, 0, '0, '0);
        send_report(500, 500, BTN_ONE, 1'b1, 1'b1);
        send_tick();
        send_report(500, 500, BTN_RELEASED, 1'b1, 1'b1);
        send_report(700, 700, BTN_ONE, 1'b0, 1'b1);
        send_report(700, 700, BTN_TWO, 1'b0, 1'b1);
        send_tick();
        send_report(700, 700, BTN_RELEASED, 1'b0, 1'b1);
        send_report(4095, 4095, BTN_ONE, 1'b0, 1'b0);
        send_tick();
        send_report(4095, 4095, BTN_RELEASED, 1'b0, 1'b0);

        // opposite extremes: hold of one tick, every slot defined, any move swipes
        program_thresholds(0, 4095, 0, 4095, 0, 1, '1, '1);
        send_report(0, 0, BTN_ONE, 1'b1, 1'b1);
        send_tick();
        send_report(1, 0, BTN_RELEASED, 1'b1, 1'b1);
        send_report(0, 4095, BTN_ONE, 1'b1, 1'b0);
        send_report(4095, 0, BTN_RELEASED, 1'b1, 1'b0);

        for (int p = 0; p < 8; p++) begin
            if (p == 5) begin
                program_thresholds(RST_LEFT_END, RST_RIGHT_START, RST_TOP_END,
                                   RST_BOTTOM_START, 4095, 65535,
                                   TAP_MASK_BITS'({$urandom, $urandom}), 8'($urandom));
            end else begin
                program_thresholds($urandom_range(4095), $urandom_range(4095),
                                   $urandom_range(4095), $urandom_range(4095),
                                   $urandom_range(300), $urandom_range(6),
                                   TAP_MASK_BITS'({$urandom, $urandom}), 8'($urandom));
            end
            set_idling(p % 4);
            random_phase(50);
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[touch_gesture_classifier_core] OK");
        end else begin
            $display("[touch_gesture_classifier_core] ERROR");
        end
        $finish;
    end

endmodule
